[design/bgsa_pkg.sv]
// Package for the block-growing slot allocator.
// Holds status and register codes, reset values and the controller/datapath structs.
// Depends on nothing; the controller, datapath, top unit and testbench import it.
`timescale 1ns / 1ps

package bgsa_pkg;

  // Bitmap rows: 16 slots per memory word.
  localparam int ROW_BITS = 16;
  localparam int ROW_LG   = 4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // Request function codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BUFFER_SIZE  = 3'd0;
  localparam logic [2:0] CFG_ENTRIES      = 3'd1;
  localparam logic [2:0] CFG_STORAGE_USE  = 3'd2;
  localparam logic [2:0] CFG_UNIFORM_USE  = 3'd3;
  localparam logic [2:0] CFG_STORAGE_LG   = 3'd4;
  localparam logic [2:0] CFG_UNIFORM_LG   = 3'd5;

  // Configuration reset values.
  localparam logic [15:0] RST_BUFFER_SIZE = 16'd256;
  localparam logic [8:0]  RST_ENTRIES     = 9'd16;
  localparam logic        RST_STORAGE_USE = 1'b0;
  localparam logic        RST_UNIFORM_USE = 1'b1;
  localparam logic [3:0]  RST_STORAGE_LG  = 4'd4;
  localparam logic [3:0]  RST_UNIFORM_LG  = 4'd8;

  typedef struct packed {
    logic [15:0] buffer_size;
    logic [8:0]  entries_per_block;
    logic        storage_usage;
    logic        uniform_usage;
    logic [3:0]  storage_align_log2;
    logic [3:0]  uniform_align_log2;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       free_rd;
    logic       free_wr;
    logic       scan;
    logic       open_rd;
    logic       open_wr;
    logic       div_step;
    logic       mul;
    logic       set_err;
    logic [1:0] err_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic free_oor;
    logic bit_set;
    logic hit;
    logic scan_end;
    logic full;
    logic open_last;
    logic div_last;
  } sts_t;

endpackage

[design/bgsa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the free bitmap rows; no dependencies.
`timescale 1ns / 1ps

module bgsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/bgsa_ctrl.sv]
// Controller state machine of the slot allocator.
// Sequences free, scan, block open, divide and multiply steps; uses bgsa_pkg.
`timescale 1ns / 1ps

module bgsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           func,
  input  bgsa_pkg::sts_t sts,
  output bgsa_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);

  import bgsa_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_FREE_RD  = 9'b000000010,
    S_FREE_CHK = 9'b000000100,
    S_SCAN     = 9'b000001000,
    S_OPEN_RD  = 9'b000010000,
    S_OPEN_WR  = 9'b000100000,
    S_DIV      = 9'b001000000,
    S_MUL      = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (func == FUNC_FREE) begin
            if (sts.free_oor) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_BAD_FREE;
              state_next   = S_RESP;
            end else begin
              state_next = S_FREE_RD;
            end
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_next  = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        // A slot whose bit is already set is free already: the release is refused.
        if (sts.bit_set) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_BAD_FREE;
        end else begin
          cmd.free_wr = 1'b1;
        end
        state_next = S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_next = S_DIV;
        end else if (sts.scan_end) begin
          if (sts.full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_FULL;
            state_next   = S_RESP;
          end else begin
            state_next = S_OPEN_RD;
          end
        end
      end
      S_OPEN_RD: begin
        cmd.open_rd = 1'b1;
        state_next  = S_OPEN_WR;
      end
      S_OPEN_WR: begin
        cmd.open_wr = 1'b1;
        if (sts.open_last) begin
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");
  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("block went idle without delivering a result");
`endif

endmodule

[design/bgsa_dpath.sv]
// Datapath of the slot allocator: bitmap memory, open-slot counters, row scan,
// restoring divider and offset multipliers. Uses bgsa_pkg and bgsa_ram.
`timescale 1ns / 1ps

module bgsa_dpath #(
  parameter int MAX_SLOTS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  bgsa_pkg::cfg_t cfg,
  input  bgsa_pkg::cmd_t cmd,
  input  logic [7:0]     free_index,
  output bgsa_pkg::sts_t sts,
  output logic [1:0]     status,
  output logic [7:0]     slot_index,
  output logic [7:0]     block_index,
  output logic [23:0]    byte_offset,
  output logic [15:0]    view_size,
  output logic           new_block,
  output logic [24:0]    block_bytes
);

  import bgsa_pkg::*;

  localparam int NROWS = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int SW    = ROW_W + ROW_LG;
  localparam int OS_W  = $clog2(MAX_SLOTS + 1);
  localparam int SUM_W = ((OS_W > 9) ? OS_W : 9) + 1;
  localparam int QW    = (SW > OS_W) ? SW : OS_W;
  localparam int DC_W  = $clog2(QW);

  function automatic logic [16:0] align_up(input logic [16:0] x, input logic [3:0] lg);
    logic [16:0] m;
    m = (17'd1 << lg) - 17'd1;
    return (x + m) & ~m;
  endfunction

  // Architectural state.
  logic [OS_W-1:0]  open_slots;
  logic [OS_W-1:0]  block_count;
  logic [NROWS-1:0] row_valid;

  // Per-item registers.
  logic [7:0]       fidx;
  logic [16:0]      sz_r;
  logic [ROW_W:0]   scan_row;
  logic [ROW_W-1:0] rd_row;
  logic             chk_vld;
  logic [SW-1:0]    slot;
  logic [QW-1:0]    quo;
  logic [8:0]       rem;
  logic [DC_W-1:0]  div_cnt;
  logic [ROW_W-1:0] open_row;
  logic             first_wr;
  logic [1:0]       status_r;
  logic             grant;
  logic             new_blk;
  logic [23:0]      byte_off;
  logic [24:0]      blk_bytes;

  // Memory ports.
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [ROW_BITS-1:0] wr_data;
  logic                rd_en;
  logic [ROW_W-1:0]    rd_addr;
  logic [ROW_BITS-1:0] rd_data;

  // Combinational helpers.
  logic [8:0]          n;
  logic [16:0]         sz_st;
  logic [16:0]         sz;
  logic [ROW_BITS-1:0] row_data;
  logic [ROW_LG-1:0]   pos;
  logic                any_free;
  logic [SW-1:0]       fidx_slot;
  logic [ROW_W-1:0]    fidx_row;
  logic [ROW_BITS-1:0] fidx_hot;
  logic [ROW_BITS-1:0] pos_hot;
  logic [SUM_W-1:0]    lo;
  logic [SUM_W-1:0]    hi;
  logic [ROW_W-1:0]    first_row;
  logic [ROW_W-1:0]    last_row;
  logic [ROW_BITS-1:0] open_mask;
  logic                scan_rd;
  logic                hit;
  logic [9:0]          trial;

  assign n     = (cfg.entries_per_block == 9'd0) ? 9'd1 : cfg.entries_per_block;
  assign sz_st = cfg.storage_usage ? align_up({1'b0, cfg.buffer_size}, cfg.storage_align_log2)
                                   : {1'b0, cfg.buffer_size};
  assign sz    = cfg.uniform_usage ? align_up(sz_st, cfg.uniform_align_log2) : sz_st;

  // Rows never written since reset read as all zero.
  assign row_data = rd_data & {ROW_BITS{row_valid[rd_row]}};

  always_comb begin
    pos = '0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (row_data[j]) begin
        pos = ROW_LG'(j);
      end
    end
  end

  assign any_free  = |row_data;
  assign fidx_slot = SW'(fidx);
  assign fidx_row  = ROW_W'(fidx_slot >> ROW_LG);
  assign fidx_hot  = ROW_BITS'(1) << fidx[ROW_LG-1:0];
  assign pos_hot   = ROW_BITS'(1) << pos;

  // New block covers [open_slots, open_slots + n); its first slot is granted at once.
  assign lo        = SUM_W'(open_slots) + SUM_W'(1);
  assign hi        = SUM_W'(open_slots) + SUM_W'(n);
  assign first_row = ROW_W'(open_slots >> ROW_LG);
  assign last_row  = ROW_W'((hi - SUM_W'(1)) >> ROW_LG);

  always_comb begin
    logic [SUM_W-1:0] idx;
    for (int j = 0; j < ROW_BITS; j++) begin
      idx          = SUM_W'({open_row, ROW_LG'(j)});
      open_mask[j] = (idx >= lo) && (idx < hi);
    end
  end

  assign scan_rd = cmd.scan && (scan_row < (ROW_W + 1)'(NROWS));
  assign hit     = cmd.scan && chk_vld && any_free;
  assign trial   = {rem, quo[QW-1]};

  assign sts.free_oor  = (SUM_W'(free_index) >= SUM_W'(open_slots));
  assign sts.bit_set   = row_data[fidx[ROW_LG-1:0]];
  assign sts.hit       = hit;
  assign sts.scan_end  = !chk_vld && (scan_row == (ROW_W + 1)'(NROWS));
  assign sts.full      = (hi > SUM_W'(MAX_SLOTS));
  assign sts.open_last = (open_row == last_row);
  assign sts.div_last  = (div_cnt == DC_W'(QW - 1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.free_rd) begin
      rd_en   = 1'b1;
      rd_addr = fidx_row;
    end else if (scan_rd) begin
      rd_en   = 1'b1;
      rd_addr = scan_row[ROW_W-1:0];
    end else if (cmd.open_rd) begin
      rd_en   = 1'b1;
      rd_addr = first_row;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.free_wr) begin
      wr_en   = 1'b1;
      wr_addr = fidx_row;
      wr_data = row_data | fidx_hot;
    end else if (hit) begin
      wr_en   = 1'b1;
      wr_addr = rd_row;
      wr_data = row_data & ~pos_hot;
    end else if (cmd.open_wr) begin
      // Only the first row can hold slots of earlier blocks.
      wr_en   = 1'b1;
      wr_addr = open_row;
      wr_data = (first_wr ? row_data : '0) | open_mask;
    end
  end

  bgsa_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (NROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_slots  <= '0;
      block_count <= '0;
      row_valid   <= '0;
      chk_vld     <= 1'b0;
      grant       <= 1'b0;
      new_blk     <= 1'b0;
      status_r    <= ST_OK;
    end else begin
      chk_vld <= scan_rd;
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (cmd.accept) begin
        grant    <= 1'b0;
        new_blk  <= 1'b0;
        status_r <= ST_OK;
      end
      if (hit) begin
        grant <= 1'b1;
      end
      if (cmd.open_rd) begin
        grant   <= 1'b1;
        new_blk <= 1'b1;
      end
      if (cmd.open_wr && sts.open_last) begin
        open_slots  <= OS_W'(hi);
        block_count <= block_count + OS_W'(1);
      end
      if (cmd.set_err) begin
        status_r <= cmd.err_code;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fidx     <= free_index;
      sz_r     <= sz;
      scan_row <= '0;
    end
    if (scan_rd) begin
      scan_row <= scan_row + (ROW_W + 1)'(1);
    end
    if (rd_en) begin
      rd_row <= rd_addr;
    end
    if (hit) begin
      slot    <= {rd_row, pos};
      quo     <= QW'({rd_row, pos});
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.open_rd) begin
      slot     <= SW'(open_slots);
      quo      <= QW'(block_count);
      rem      <= '0;
      open_row <= first_row;
      first_wr <= 1'b1;
    end
    if (cmd.open_wr) begin
      first_wr <= 1'b0;
      open_row <= open_row + ROW_W'(1);
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + DC_W'(1);
      if (trial >= {1'b0, n}) begin
        rem <= 9'(trial - {1'b0, n});
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= trial[8:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      byte_off  <= 24'(rem * sz_r);
      blk_bytes <= 25'(sz_r * n);
    end
  end

  assign status      = status_r;
  assign slot_index  = grant ? 8'(slot) : 8'd0;
  assign block_index = grant ? 8'(quo) : 8'd0;
  assign byte_offset = grant ? byte_off : 24'd0;
  assign view_size   = grant ? cfg.buffer_size : 16'd0;
  assign new_block   = new_blk;
  assign block_bytes = grant ? blk_bytes : 25'd0;

`ifndef SYNTHESIS
  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open_slots <= OS_W'(MAX_SLOTS))
    else $error("open slot count beyond pool size");
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.free_wr, hit, cmd.open_wr}))
    else $error("two bitmap writers in one cycle");
  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    grant |-> (status_r == ST_OK))
    else $error("granted slot with error status");
`endif

endmodule

[design/block_growing_slot_allocator_unit.sv]
// Free request: after accept the row is read and checked, the slot's bit is set if it was
// clear, and the result is strobed; an unopened index goes straight to the result.
// Allocate: scan of R = ceil(MAX_SLOTS/16) bitmap rows, one row per cycle; a hit then
// runs the divider (QW = divider width, 9 at 256 slots) and the multiply step, a new
// block writes its rows and multiplies, pool full answers after the scan. One item at a
// time: the next is accepted in the cycle after the strobe; results cannot be stalled.
// Synchronous reset closes all slots at once and restores the register defaults.
`timescale 1ns / 1ps

module block_growing_slot_allocator_unit #(
  parameter int MAX_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [7:0]  free_index,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  slot_index,
  output logic [7:0]  block_index,
  output logic [23:0] byte_offset,
  output logic [15:0] view_size,
  output logic        new_block,
  output logic [24:0] block_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import bgsa_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_size        <= RST_BUFFER_SIZE;
      cfg.entries_per_block  <= RST_ENTRIES;
      cfg.storage_usage      <= RST_STORAGE_USE;
      cfg.uniform_usage      <= RST_UNIFORM_USE;
      cfg.storage_align_log2 <= RST_STORAGE_LG;
      cfg.uniform_align_log2 <= RST_UNIFORM_LG;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BUFFER_SIZE: cfg.buffer_size        <= cfg_data;
        CFG_ENTRIES:     cfg.entries_per_block  <= cfg_data[8:0];
        CFG_STORAGE_USE: cfg.storage_usage      <= cfg_data[0];
        CFG_UNIFORM_USE: cfg.uniform_usage      <= cfg_data[0];
        CFG_STORAGE_LG:  cfg.storage_align_log2 <= cfg_data[3:0];
        CFG_UNIFORM_LG:  cfg.uniform_align_log2 <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  bgsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bgsa_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .free_index  (free_index),
    .sts         (sts),
    .status      (status),
    .slot_index  (slot_index),
    .block_index (block_index),
    .byte_offset (byte_offset),
    .view_size   (view_size),
    .new_block   (new_block),
    .block_bytes (block_bytes)
  );

endmodule

[test/block_growing_slot_allocator_unit_tb.sv]
// Self-checking testbench for the block-growing slot allocator.
// Drives allocate and free items against an internal prediction of the pool state.
// Depends on bgsa_pkg and block_growing_slot_allocator_unit.
`timescale 1ns / 1ps

module block_growing_slot_allocator_unit_tb;
  import bgsa_pkg::*;

  localparam int POOL_SLOTS = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [7:0]  block_index;
    logic [23:0] byte_offset;
    logic [15:0] view_size;
    logic        new_block;
    logic [24:0] block_bytes;
  } grant_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        func;
  logic [7:0]  free_index;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  slot_index;
  logic [7:0]  block_index;
  logic [23:0] byte_offset;
  logic [15:0] view_size;
  logic        new_block;
  logic [24:0] block_bytes;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Shadow of the pool: register values, free bitmap and growth counters.
  cfg_t        shadow_cfg;
  bit          slot_free [POOL_SLOTS];
  int unsigned open_count;
  int unsigned blocks_opened;
  int          live_slots[$];
  logic [7:0]  last_released;

  grant_t      expected_grants[$];
  int          mismatch_count;

  block_growing_slot_allocator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .free_index  (free_index),
    .done        (done),
    .status      (status),
    .slot_index  (slot_index),
    .block_index (block_index),
    .byte_offset (byte_offset),
    .view_size   (view_size),
    .new_block   (new_block),
    .block_bytes (block_bytes),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned round_up(input int unsigned x, input logic [3:0] lg);
    int unsigned a;
    a = 32'd1 << lg;
    return (x + a - 1) & ~(a - 1);
  endfunction

  // Works out the result of one accepted item and advances the shadow pool.
  function automatic grant_t predict_grant(input logic f, input logic [7:0] idx);
    grant_t          g;
    int unsigned     n;
    int unsigned     sz;
    int unsigned     slot;
    int unsigned     blk;
    int unsigned     lcl;
    bit              found;
    bit              opened;
    longint unsigned prod;
    int              hits[$];
    g = '0;
    g.status = ST_OK;
    found = 1'b0;
    opened = 1'b0;
    slot = 0;
    n = (shadow_cfg.entries_per_block == 9'd0) ? 1 : shadow_cfg.entries_per_block;
    sz = shadow_cfg.buffer_size;
    if (shadow_cfg.storage_usage) sz = round_up(sz, shadow_cfg.storage_align_log2);
    if (shadow_cfg.uniform_usage) sz = round_up(sz, shadow_cfg.uniform_align_log2);

    if (f == FUNC_FREE) begin
      if (idx >= open_count || slot_free[idx]) begin
        g.status = ST_BAD_FREE;
      end else begin
        slot_free[idx] = 1'b1;
        last_released = idx;
        hits = live_slots.find_first_index(x) with (x == int'(idx));
        if (hits.size() != 0) live_slots.delete(hits[0]);
      end
      return g;
    end

    for (int i = 0; i < int'(open_count) && i < POOL_SLOTS; i++) begin
      if (slot_free[i]) begin
        slot = i;
        found = 1'b1;
        break;
      end
    end

    if (found) begin
      blk = slot / n;
    end else begin
      if (open_count + n > POOL_SLOTS) begin
        g.status = ST_FULL;
        return g;
      end
      slot = open_count;
      blk = blocks_opened;
      for (int i = open_count; i < int'(open_count + n) && i < POOL_SLOTS; i++) begin
        slot_free[i] = 1'b1;
      end
      open_count = open_count + n;
      blocks_opened = blocks_opened + 1;
      opened = 1'b1;
    end

    slot_free[slot] = 1'b0;
    live_slots.push_back(slot);
    lcl = opened ? 0 : slot - blk * n;
    g.slot_index = slot[7:0];
    g.block_index = blk[7:0];
    prod = longint'(lcl) * longint'(sz);
    g.byte_offset = prod[23:0];
    g.view_size = shadow_cfg.buffer_size;
    g.new_block = opened;
    prod = longint'(sz) * longint'(n);
    g.block_bytes = prod[24:0];
    return g;
  endfunction

  // Presents one item at a falling edge and holds it until accepted.
  // Start is left high so that a following item can go out back to back.
  task automatic send_item(input logic f, input logic [7:0] idx);
    start = 1'b1;
    func = f;
    free_index = idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_grants.push_back(predict_grant(f, idx));
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (expected_grants.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_BUFFER_SIZE: shadow_cfg.buffer_size = data;
      CFG_ENTRIES:     shadow_cfg.entries_per_block = data[8:0];
      CFG_STORAGE_USE: shadow_cfg.storage_usage = data[0];
      CFG_UNIFORM_USE: shadow_cfg.uniform_usage = data[0];
      CFG_STORAGE_LG:  shadow_cfg.storage_align_log2 = data[3:0];
      CFG_UNIFORM_LG:  shadow_cfg.uniform_align_log2 = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only once every pending item has produced its result.
  task automatic apply_setting(input logic [15:0] bsize, input logic [8:0] entries,
                               input logic s_use, input logic u_use,
                               input logic [3:0] s_lg, input logic [3:0] u_lg);
    wait_drained();
    write_reg(CFG_BUFFER_SIZE, bsize);
    write_reg(CFG_ENTRIES, {7'd0, entries});
    write_reg(CFG_STORAGE_USE, {15'd0, s_use});
    write_reg(CFG_UNIFORM_USE, {15'd0, u_use});
    write_reg(CFG_STORAGE_LG, {12'd0, s_lg});
    write_reg(CFG_UNIFORM_LG, {12'd0, u_lg});
  endtask

  // Reset settings: bad frees on closed slots, first block, reuse and double free.
  task automatic test_basic_grants();
    send_item(FUNC_FREE, 8'd0);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_ALLOC, 8'hFF);
    send_item(FUNC_FREE, 8'd1);
    send_item(FUNC_FREE, 8'd1);
    send_item(FUNC_FREE, 8'd255);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_FREE, 8'd15);
    send_item(FUNC_FREE, 8'd16);
    pause_sender(1);
  endtask

  // Zero size, largest alignments, oversized and zero block lengths.
  task automatic test_size_extremes();
    apply_setting(16'd0, 9'd16, 1'b1, 1'b1, 4'd15, 4'd15);
    send_item(FUNC_ALLOC, 8'd0);
    apply_setting(16'hFFFF, 9'd256, 1'b1, 1'b1, 4'd15, 4'd15);
    send_item(FUNC_ALLOC, 8'd0);
    apply_setting(16'hFFFF, 9'd511, 1'b1, 1'b0, 4'd15, 4'd0);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_FREE, 8'd2);
    apply_setting(16'd1, 9'd0, 1'b0, 1'b1, 4'd0, 4'd8);
    send_item(FUNC_ALLOC, 8'd0);
    send_item(FUNC_ALLOC, 8'd0);
    pause_sender(1);
  endtask

  task automatic run_traffic_phase(input int count, input int alloc_pct);
    int         sent;
    int         burst;
    int         gap;
    int         pick;
    logic [7:0] idx;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < count; k++) begin
        if (int'($urandom_range(99)) < alloc_pct) begin
          send_item(FUNC_ALLOC, 8'($urandom_range(255)));
        end else begin
          pick = $urandom_range(9);
          if (pick < 7 && live_slots.size() != 0)
            idx = 8'(live_slots[$urandom_range(live_slots.size() - 1)]);
          else if (pick < 8)
            idx = last_released;
          else
            idx = 8'($urandom_range(255));
          send_item(FUNC_FREE, idx);
        end
        sent++;
        // At the halfway point, hold the sender off until the pool has answered everything.
        if (sent == count / 2) wait_drained();
      end
      gap = ($urandom_range(3) == 0) ? 0 :
            ($urandom_range(3) == 0) ? $urandom_range(5, 45) : $urandom_range(1, 3);
      if (gap != 0) pause_sender(gap);
    end
    pause_sender(1);
  endtask

  // Random traffic under a sweep of register settings.
  task automatic test_setting_sweep();
    apply_setting(RST_BUFFER_SIZE, RST_ENTRIES, RST_STORAGE_USE, RST_UNIFORM_USE,
                  RST_STORAGE_LG, RST_UNIFORM_LG);
    run_traffic_phase(220, 65);
    apply_setting(16'd100, 9'd3, 1'b1, 1'b1, 4'd5, 4'd6);
    run_traffic_phase(220, 60);
    apply_setting(16'hFFFF, 9'd256, 1'b1, 1'b1, 4'd15, 4'd15);
    run_traffic_phase(180, 55);
    apply_setting(16'd0, 9'd0, 1'b1, 1'b0, 4'd8, 4'd0);
    run_traffic_phase(220, 60);
    apply_setting(16'd1, 9'd511, 1'b0, 1'b0, 4'd0, 4'd0);
    run_traffic_phase(180, 50);
    apply_setting(16'd777, 9'd7, 1'b1, 1'b0, 4'd3, 4'd15);
    run_traffic_phase(220, 55);
    apply_setting(16'd4096, 9'd1, 1'b0, 1'b1, 4'd0, 4'd2);
    run_traffic_phase(220, 60);
    apply_setting(16'($urandom_range(1, 65535)), 9'($urandom_range(1, 32)),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  4'($urandom_range(15)), 4'($urandom_range(15)));
    run_traffic_phase(220, 50);
    apply_setting(16'd300, 9'd2, 1'b1, 1'b1, 4'd2, 4'd8);
    run_traffic_phase(200, 45);
  endtask

  // Each strobed result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (!rst && done) begin
      got = '{status, slot_index, block_index, byte_offset, view_size, new_block,
              block_bytes};
      if (expected_grants.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no item outstanding: status %0d slot %0d",
                   $realtime, got.status, got.slot_index);
      end else begin
        want = expected_grants.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch, expected st %0d slot %0d blk %0d off %0d view %0d nb %0d bb %0d",
                     $realtime, want.status, want.slot_index, want.block_index,
                     want.byte_offset, want.view_size, want.new_block, want.block_bytes);
            $display("%0t:           actual   st %0d slot %0d blk %0d off %0d view %0d nb %0d bb %0d",
                     $realtime, got.status, got.slot_index, got.block_index,
                     got.byte_offset, got.view_size, got.new_block, got.block_bytes);
          end
        end
      end
    end
  end

  initial begin
    #(64'd20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_ALLOC;
    free_index = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BUFFER_SIZE;
    cfg_data = 16'd0;
    mismatch_count = 0;
    shadow_cfg.buffer_size = RST_BUFFER_SIZE;
    shadow_cfg.entries_per_block = RST_ENTRIES;
    shadow_cfg.storage_usage = RST_STORAGE_USE;
    shadow_cfg.uniform_usage = RST_UNIFORM_USE;
    shadow_cfg.storage_align_log2 = RST_STORAGE_LG;
    shadow_cfg.uniform_align_log2 = RST_UNIFORM_LG;
    foreach (slot_free[i]) slot_free[i] = 1'b0;
    open_count = 0;
    blocks_opened = 0;
    last_released = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_grants();
    test_size_extremes();
    test_setting_sweep();

    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && expected_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
design/bgsa_pkg.sv
design/bgsa_ram.sv
design/bgsa_ctrl.sv
design/bgsa_dpath.sv
design/block_growing_slot_allocator_unit.sv
test/block_growing_slot_allocator_unit_tb.sv
